/* rtl/rfi_jvp_pkg.sv */
// shared types and constants for the rfi visibility tangent accumulator
package rfi_jvp_pkg;

  typedef struct packed {
    logic [31:0]        amp_a;
    logic [31:0]        amp_b;
    logic [31:0]        amp_tangent_a;
    logic [31:0]        amp_tangent_b;
    logic [15:0]        phase_a;
    logic [15:0]        phase_b;
    logic signed [15:0] phase_tangent_a;
    logic signed [15:0] phase_tangent_b;
    logic               last;
  } rfi_jvp_in_t;

  typedef struct packed {
    logic signed [31:0] grad_real;
    logic signed [31:0] grad_imag;
  } rfi_jvp_out_t;

  localparam int CordicSteps = 16;
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;
  localparam logic signed [47:0] SumMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SumMin = 48'sh8000_0000_0000;

  function automatic logic signed [25:0] atan_turn(input logic [3:0] i);
    case (i)
      4'd0:    atan_turn = 26'sd2097152;
      4'd1:    atan_turn = 26'sd1238021;
      4'd2:    atan_turn = 26'sd654136;
      4'd3:    atan_turn = 26'sd332050;
      4'd4:    atan_turn = 26'sd166669;
      4'd5:    atan_turn = 26'sd83416;
      4'd6:    atan_turn = 26'sd41718;
      4'd7:    atan_turn = 26'sd20860;
      4'd8:    atan_turn = 26'sd10430;
      4'd9:    atan_turn = 26'sd5215;
      4'd10:   atan_turn = 26'sd2608;
      4'd11:   atan_turn = 26'sd1304;
      4'd12:   atan_turn = 26'sd652;
      4'd13:   atan_turn = 26'sd326;
      4'd14:   atan_turn = 26'sd163;
      default: atan_turn = 26'sd81;
    endcase
  endfunction

endpackage

/* rtl/rfi_jvp_cordic.sv */
// iterative cordic: one rotation step per cycle, cos/sin of a turn fraction in q1.14
module rfi_jvp_cordic import rfi_jvp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [15:0]        phase,
  output logic               done,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} cst_t;
  cst_t state_r;
  logic [3:0] step_r;
  logic [1:0] quad_r;
  logic signed [33:0] x_r, y_r;
  logic signed [25:0] z_r;
  logic signed [15:0] cos_r, sin_r;
  logic done_r;

  logic [15:0] qsum, resid;
  logic [1:0]  quad;
  logic signed [33:0] dx, dy;
  logic signed [17:0] cr, sr, cc, ss;

  assign qsum  = phase + 16'd8192;
  assign quad  = qsum[15:14];
  assign resid = phase - {quad, 14'd0};
  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;

  function automatic logic signed [17:0] rnd_clamp(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [17:0] r;
    t = (v + 34'sd32768) >>> 16;
    r = t[17:0];
    if (r > 18'sd16384) r = 18'sd16384;
    if (r < -18'sd16384) r = -18'sd16384;
    return r;
  endfunction

  assign cr = rnd_clamp(x_r);
  assign sr = rnd_clamp(y_r);

  always_comb begin
    case (quad_r)
      2'd0:    begin cc = cr;  ss = sr;  end
      2'd1:    begin cc = -sr; ss = cr;  end
      2'd2:    begin cc = -cr; ss = -sr; end
      default: begin cc = sr;  ss = -cr; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            x_r     <= CordicX0;
            y_r     <= '0;
            z_r     <= 26'(signed'(resid)) <<< 8;
            quad_r  <= quad;
            step_r  <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (!z_r[25]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - atan_turn(step_r);
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + atan_turn(step_r);
          end
          step_r <= step_r + 4'd1;
          if (step_r == 4'(CordicSteps - 1)) state_r <= S_FIN;
        end
        S_FIN: begin
          cos_r   <= cc[15:0];
          sin_r   <= ss[15:0];
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

/* rtl/rfi_visibility_jvp_accumulate.sv */
// rfi visibility tangent accumulator: top level with shared multiplier sequencer
// sequence: the multiply steps run while the cordic rotates the phase difference, then the
// rotate steps follow once the cordic is done; a last item adds the output steps. a new
// item is taken only once the previous one is through, as the serial cordic and the one
// shared multiplier are busy until then; a result still waiting only stalls the final
// output step of the next last item. reset (synchronous, active low):
// sums cleared, scale set to 1.0, no result pending.
module rfi_visibility_jvp_accumulate import rfi_jvp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  rfi_jvp_in_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output rfi_jvp_out_t out_data,
  input  logic         cfg_we,
  input  logic [16:0]  cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_WAIT, S_ROT, S_OUT, S_HOLD} st_t;
  st_t state_r;
  logic [3:0] step_r;
  rfi_jvp_in_t item_r;
  logic [16:0] scale_r;
  logic signed [47:0] sum_re_r, sum_im_r;
  logic signed [37:0] ir_r, ii_r;
  logic signed [33:0] mr_r, mi_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] res_re_r;
  logic out_valid_r;
  rfi_jvp_out_t out_r;

  logic cord_start, cord_done;
  logic signed [15:0] cos_v, sin_v;

  rfi_jvp_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cord_start),
    .phase(in_data.phase_a - in_data.phase_b),
    .done(cord_done), .cos_o(cos_v), .sin_o(sin_v)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign cord_start = in_valid && in_ready;

  function automatic logic signed [15:0] hi16(input logic [31:0] v);
    return signed'(v[31:16]);
  endfunction
  function automatic logic signed [15:0] lo16(input logic [31:0] v);
    return signed'(v[15:0]);
  endfunction

  // shared multiplier operands
  logic signed [37:0] op_a;
  logic signed [17:0] op_b;
  logic signed [55:0] prod;
  logic signed [16:0] dp;
  logic signed [47:0] mag_sum;
  logic signed [47:0] cur_sum;
  logic               cur_neg;
  logic               out_load;

  assign dp = 17'(item_r.phase_tangent_a) - 17'(item_r.phase_tangent_b);
  assign cur_sum = (step_r[1] == 1'b0) ? sum_re_r : sum_im_r;
  assign cur_neg = cur_sum[47];
  assign mag_sum = cur_neg ? -cur_sum : cur_sum;
  assign out_load = (state_r == S_OUT) && (step_r == 4'd3) && (!out_valid_r || out_ready);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_MUL: begin
        case (step_r)
          4'd0: begin op_a = 38'(hi16(item_r.amp_tangent_a)); op_b = 18'(hi16(item_r.amp_b)); end
          4'd1: begin op_a = 38'(lo16(item_r.amp_tangent_a)); op_b = 18'(lo16(item_r.amp_b)); end
          4'd2: begin op_a = 38'(hi16(item_r.amp_a)); op_b = 18'(hi16(item_r.amp_tangent_b)); end
          4'd3: begin op_a = 38'(lo16(item_r.amp_a)); op_b = 18'(lo16(item_r.amp_tangent_b)); end
          4'd4: begin op_a = 38'(lo16(item_r.amp_tangent_a)); op_b = 18'(hi16(item_r.amp_b)); end
          4'd5: begin op_a = -38'(hi16(item_r.amp_tangent_a)); op_b = 18'(lo16(item_r.amp_b)); end
          4'd6: begin op_a = 38'(lo16(item_r.amp_a)); op_b = 18'(hi16(item_r.amp_tangent_b)); end
          4'd7: begin op_a = -38'(hi16(item_r.amp_a)); op_b = 18'(lo16(item_r.amp_tangent_b)); end
          4'd8: begin op_a = 38'(hi16(item_r.amp_a)); op_b = 18'(hi16(item_r.amp_b)); end
          4'd9: begin op_a = 38'(lo16(item_r.amp_a)); op_b = 18'(lo16(item_r.amp_b)); end
          4'd10: begin op_a = 38'(lo16(item_r.amp_a)); op_b = 18'(hi16(item_r.amp_b)); end
          4'd11: begin op_a = -38'(hi16(item_r.amp_a)); op_b = 18'(lo16(item_r.amp_b)); end
          4'd12: begin op_a = -38'(mi_r); op_b = 18'(dp); end
          default: begin op_a = 38'(mr_r); op_b = 18'(dp); end
        endcase
      end
      S_ROT: begin
        case (step_r)
          4'd0: begin op_a = ir_r; op_b = 18'(cos_v); end
          4'd1: begin op_a = -ii_r; op_b = 18'(sin_v); end
          4'd2: begin op_a = ir_r; op_b = 18'(sin_v); end
          default: begin op_a = ii_r; op_b = 18'(cos_v); end
        endcase
      end
      // magnitude times scale in two halves: low 24 bits, then high 24 bits
      S_OUT: begin
        if (step_r[0] == 1'b0) op_a = 38'(mag_sum[23:0]);
        else op_a = 38'(mag_sum[47:24]);
        op_b = 18'(scale_r);
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod = op_a * op_b;

  // q42 product to q20, then saturating add to the sum
  function automatic logic signed [47:0] sat_add(input logic signed [47:0] s,
                                                 input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [63:0] w;
    t = (p + 64'sd2097152) >>> 22;
    w = 64'(s) + t;
    if (w > 64'(SumMax)) return SumMax;
    if (w < 64'(SumMin)) return SumMin;
    return w[47:0];
  endfunction

  // |sum|*scale rounded to q14, sign restored, saturated
  logic [64:0] big;
  logic [63:0] pmag;
  logic signed [31:0] outv;
  always_comb begin
    big  = 65'(unsigned'(acc_r)) + (65'(unsigned'(prod)) << 24);
    pmag = (big[63:0] + 64'd2097152) >> 22;
    if (pmag > 64'h8000_0000) pmag = 64'h8000_0000;
    if (cur_neg) outv = (pmag == 64'h8000_0000) ? 32'sh8000_0000 : -signed'(pmag[31:0]);
    else outv = (pmag >= 64'h8000_0000) ? 32'sh7FFF_FFFF : signed'(pmag[31:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      scale_r     <= 17'd65536;
      sum_re_r    <= '0;
      sum_im_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) scale_r <= cfg_data;
      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cord_start) begin
            item_r  <= in_data;
            step_r  <= '0;
            acc_r   <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          step_r <= step_r + 4'd1;
          case (step_r)
            4'd1: begin ir_r <= 38'(acc_r + 64'(prod)); acc_r <= '0; end
            4'd3: begin ir_r <= 38'(64'(ir_r) + acc_r + 64'(prod)); acc_r <= '0; end
            4'd5: begin ii_r <= 38'(acc_r + 64'(prod)); acc_r <= '0; end
            4'd7: begin ii_r <= 38'(64'(ii_r) + acc_r + 64'(prod)); acc_r <= '0; end
            4'd9: begin mr_r <= 34'(acc_r + 64'(prod)); acc_r <= '0; end
            4'd11: begin mi_r <= 34'(acc_r + 64'(prod)); acc_r <= '0; end
            4'd12: ir_r <= ir_r + 38'((64'(prod) + 64'sd1024) >>> 11);
            4'd13: begin
              ii_r    <= ii_r + 38'((64'(prod) + 64'sd1024) >>> 11);
              state_r <= S_WAIT;
            end
            default: acc_r <= acc_r + 64'(prod);
          endcase
        end
        S_WAIT: begin
          step_r <= '0;
          if (cord_done) state_r <= S_ROT;
        end
        S_ROT: begin
          step_r <= (step_r == 4'd3) ? 4'd0 : step_r + 4'd1;
          case (step_r)
            4'd0: acc_r <= 64'(prod);
            4'd1: sum_re_r <= sat_add(sum_re_r, acc_r + 64'(prod));
            4'd2: acc_r <= 64'(prod);
            default: begin
              sum_im_r <= sat_add(sum_im_r, acc_r + 64'(prod));
              state_r  <= item_r.last ? S_OUT : S_IDLE;
            end
          endcase
        end
        S_OUT: begin
          case (step_r)
            4'd0, 4'd2: begin
              acc_r  <= 64'(prod);
              step_r <= step_r + 4'd1;
            end
            4'd1: begin
              res_re_r <= outv;
              step_r   <= step_r + 4'd1;
            end
            default: begin
              // hold until the previous result has been taken
              if (out_load) begin
                out_r.grad_real <= res_re_r;
                out_r.grad_imag <= outv;
                out_valid_r     <= 1'b1;
                sum_re_r        <= '0;
                sum_im_r        <= '0;
                step_r          <= '0;
                state_r         <= S_IDLE;
              end
            end
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("pending result dropped or changed");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (sum_re_r == '0 && sum_im_r == '0))
    else $error("sum not cleared after result");
`endif

endmodule
